FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/core/bb3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bb3_pkg;

   localparam int PIX_BITS      = 24;
   localparam int CH_BITS       = 8;
   localparam int CFG_W_BITS    = 11;
   localparam int CFG_H_BITS    = 13;
   localparam int CSR_DATA_BITS = 13;
   localparam int SUM_BITS      = 12;
   localparam int CNT_BITS      = 4;
   localparam int RECIP_BITS    = 17;
   localparam int SHIFT_BITS    = 5;
   localparam int PROD_BITS     = 29;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TAP,
      ST_FLUSH,
      ST_MUL,
      ST_SHR,
      ST_HOLD
   } state_type;

   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic accept;
      logic tap;
      logic mul;
      logic shr;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic tap_last;
      logic ch_last;
   } status_type;

   typedef struct packed {
      logic [RECIP_BITS-1:0] mult;
      logic [SHIFT_BITS-1:0] shift;
   } recip_type;

   // Division by the neighbor count as a multiply by a scaled reciprocal.
   function automatic recip_type recip(input logic [CNT_BITS-1:0] cnt);
      recip_type r;
      case (cnt)
         4'd2:    r = '{mult: 17'd65536, shift: 5'd17};
         4'd3:    r = '{mult: 17'd21846, shift: 5'd16};
         4'd4:    r = '{mult: 17'd65536, shift: 5'd18};
         4'd6:    r = '{mult: 17'd21846, shift: 5'd17};
         4'd9:    r = '{mult: 17'd7282,  shift: 5'd16};
         default: r = '{mult: 17'd65536, shift: 5'd16};
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/box_blur_3x3_stream_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Streaming 3x3 box blur of an RGB frame sent in raster order. A word with
// tuser low carries a pixel; a word with tuser high is a drain tick that
// flushes one pending result after all pixels of the frame are in. Each
// result is the half-up rounded mean of the pixel and its in-bounds
// neighbors and leaves frame_width+1 pixels behind the input; tlast marks
// the final pixel of the frame. A word that yields no result is just accepted;
// one that yields a result occupies the block through the accept step, nine
// reads of the single-port line ring, one per neighbor, a step to fold in
// the last read, a multiply and a shift for each of the three colors through
// one shared reciprocal multiplier, and a step to load the output register,
// which waits while an earlier result is not yet taken. A finished result
// waits in the output register while the next word is taken. A register
// write restarts the frame. There is no clearing pass after reset.
module box_blur_3x3_stream_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_we,
   input  wire                                csr_index,
   input  wire  [bb3_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // red_in [7:0], green_in [15:8], blue_in [23:16]
   input  wire  [bb3_pkg::PIX_BITS-1:0]       req_tdata,
   // action [0]
   input  wire                                req_tuser,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // red_out [7:0], green_out [15:8], blue_out [23:16]
   output logic [bb3_pkg::PIX_BITS-1:0]       rsp_tdata,
   output logic                               rsp_tlast
);

   bb3_pkg::cmd_type    cmd;
   bb3_pkg::status_type status;

   bb3_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bb3_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule
`default_nettype wire

FILE: rtl/core/bb3_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module bb3_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   input  bb3_pkg::status_type  status,
   output bb3_pkg::cmd_type     cmd
);

   bb3_pkg::state_type state_ff, state_in;
   logic out_valid_ff, out_valid_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bb3_pkg::ST_IDLE:  if (req_tvalid && status.emit) state_in = bb3_pkg::ST_TAP;
         bb3_pkg::ST_TAP:   if (status.tap_last) state_in = bb3_pkg::ST_FLUSH;
         bb3_pkg::ST_FLUSH: state_in = bb3_pkg::ST_MUL;
         bb3_pkg::ST_MUL:   state_in = bb3_pkg::ST_SHR;
         bb3_pkg::ST_SHR:   state_in = status.ch_last ? bb3_pkg::ST_HOLD : bb3_pkg::ST_MUL;
         bb3_pkg::ST_HOLD:  if (!out_valid_ff || rsp_tready) state_in = bb3_pkg::ST_IDLE;
         default:           state_in = bb3_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         bb3_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         bb3_pkg::ST_TAP:  cmd.tap = 1'b1;
         bb3_pkg::ST_MUL:  cmd.mul = 1'b1;
         bb3_pkg::ST_SHR:  cmd.shr = 1'b1;
         bb3_pkg::ST_HOLD: cmd.load = !out_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   always_comb begin
      if (cmd.load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bb3_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/bb3_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module bb3_datapath #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_we,
   input  wire                                 csr_index,
   input  wire  [bb3_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  wire  [bb3_pkg::PIX_BITS-1:0]        req_tdata,
   input  wire                                 req_tuser,
   input  bb3_pkg::cmd_type                    cmd,
   output bb3_pkg::status_type                 status,
   output logic [bb3_pkg::PIX_BITS-1:0]        rsp_tdata,
   output logic                                rsp_tlast
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int FW = $clog2(MAX_WIDTH + 4);
   localparam int AW = CW + 2;
   localparam int SB = bb3_pkg::SUM_BITS;
   localparam int PB = bb3_pkg::PROD_BITS;
   localparam int CB = bb3_pkg::CH_BITS;

   logic [bb3_pkg::CFG_W_BITS-1:0] width_raw_ff, width_raw_in;
   logic [bb3_pkg::CFG_H_BITS-1:0] height_raw_ff, height_raw_in;
   logic [CW-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in, work_col_ff, work_col_in;
   logic [HW-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in, work_row_ff, work_row_in;
   logic [FW-1:0] filled_ff, filled_in;
   logic          work_last_ff, work_last_in;
   logic [1:0]    tr_ff, tr_in, tc_ff, tc_in, ch_ff, ch_in;
   logic          rd_valid_ff, rd_valid_in;
   logic [bb3_pkg::PIX_BITS-1:0] rd_data_ff;
   logic [SB-1:0] sum_ff [3];
   logic [SB-1:0] sum_in [3];
   logic [bb3_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [PB-1:0] prod_ff;
   logic [CB-1:0] q_ff [3];
   logic [bb3_pkg::PIX_BITS-1:0] rsp_data_ff;
   logic          rsp_last_ff;

   logic [bb3_pkg::PIX_BITS-1:0] ring [1 << AW];

   logic [WW-1:0] eff_w, in_col_inc, out_col_inc;
   logic [HW-1:0] eff_h, out_row_inc;
   logic          pix_ok, emit, last, row_ok, col_ok;
   logic [FW-1:0] filled_inc, fill_goal;
   logic [1:0]    slot;
   logic [CW-1:0] tap_col;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [SB-1:0] div_x;
   bb3_pkg::recip_type rc;

   always_comb begin
      if (width_raw_ff == '0) begin
         eff_w = WW'(1);
      end else if (32'(width_raw_ff) > MAX_WIDTH) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(width_raw_ff);
      end
      if (height_raw_ff == '0) begin
         eff_h = HW'(1);
      end else if (32'(height_raw_ff) > MAX_HEIGHT) begin
         eff_h = HW'(MAX_HEIGHT);
      end else begin
         eff_h = HW'(height_raw_ff);
      end
   end

   always_comb begin
      in_col_inc  = WW'(in_col_ff) + WW'(1);
      out_col_inc = WW'(out_col_ff) + WW'(1);
      out_row_inc = out_row_ff + HW'(1);
      filled_inc  = filled_ff + FW'(1);
      fill_goal   = FW'(eff_w) + FW'(2);
      pix_ok      = !req_tuser && (in_row_ff < eff_h);
      // A pixel yields a result once the window below and to the right is in.
      emit        = (pix_ok && (filled_inc >= fill_goal)) || (req_tuser && (in_row_ff >= eff_h));
      last        = (out_row_inc >= eff_h) && (out_col_inc >= eff_w);
      wr_addr     = {in_row_ff[1:0], in_col_ff};
   end

   always_comb begin
      case (tr_ff)
         2'd0:    row_ok = (work_row_ff != '0);
         2'd1:    row_ok = 1'b1;
         default: row_ok = (work_row_ff + HW'(1)) < eff_h;
      endcase
      case (tc_ff)
         2'd0:    begin col_ok = (work_col_ff != '0); tap_col = work_col_ff - CW'(1); end
         2'd1:    begin col_ok = 1'b1; tap_col = work_col_ff; end
         default: begin
            col_ok  = (WW'(work_col_ff) + WW'(1)) < eff_w;
            tap_col = work_col_ff + CW'(1);
         end
      endcase
      slot    = work_row_ff[1:0] + tr_ff - 2'd1;
      rd_addr = {slot, tap_col};
      rc      = bb3_pkg::recip(cnt_ff);
      div_x   = sum_ff[ch_ff] + SB'(cnt_ff >> 1);
   end

   assign status.emit     = emit;
   assign status.tap_last = (tr_ff == 2'd2) && (tc_ff == 2'd2);
   assign status.ch_last  = (ch_ff == 2'd2);

   always_comb begin
      width_raw_in  = width_raw_ff;
      height_raw_in = height_raw_ff;
      in_col_in     = in_col_ff;
      in_row_in     = in_row_ff;
      out_col_in    = out_col_ff;
      out_row_in    = out_row_ff;
      filled_in     = filled_ff;
      work_col_in   = work_col_ff;
      work_row_in   = work_row_ff;
      work_last_in  = work_last_ff;
      tr_in         = tr_ff;
      tc_in         = tc_ff;
      ch_in         = ch_ff;
      cnt_in        = cnt_ff;
      sum_in        = sum_ff;
      rd_valid_in   = cmd.tap && row_ok && col_ok;

      if (rd_valid_ff) begin
         for (int k = 0; k < 3; k++) begin
            sum_in[k] = sum_ff[k] + SB'(rd_data_ff[k*CB +: CB]);
         end
         cnt_in = cnt_ff + bb3_pkg::CNT_BITS'(1);
      end

      if (cmd.tap) begin
         if (tc_ff == 2'd2) begin
            tc_in = 2'd0;
            tr_in = tr_ff + 2'd1;
         end else begin
            tc_in = tc_ff + 2'd1;
         end
      end

      if (cmd.shr) begin
         ch_in = ch_ff + 2'd1;
      end

      if (cmd.accept) begin
         if (pix_ok) begin
            if (in_col_inc >= eff_w) begin
               in_col_in = '0;
               in_row_in = in_row_ff + HW'(1);
            end else begin
               in_col_in = CW'(in_col_inc);
            end
            if (filled_ff < fill_goal) begin
               filled_in = filled_inc;
            end
         end
         if (emit) begin
            work_col_in  = out_col_ff;
            work_row_in  = out_row_ff;
            work_last_in = last;
            tr_in        = 2'd0;
            tc_in        = 2'd0;
            ch_in        = 2'd0;
            cnt_in       = '0;
            for (int k = 0; k < 3; k++) begin
               sum_in[k] = '0;
            end
            if (last) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
               filled_in  = '0;
            end else if (out_col_inc >= eff_w) begin
               out_col_in = '0;
               out_row_in = out_row_inc;
            end else begin
               out_col_in = CW'(out_col_inc);
            end
         end
      end

      // Any register write restarts the frame.
      if (csr_we) begin
         unique case (bb3_pkg::reg_index_type'(csr_index))
            bb3_pkg::REG_FRAME_WIDTH:  width_raw_in = csr_wdata[bb3_pkg::CFG_W_BITS-1:0];
            bb3_pkg::REG_FRAME_HEIGHT: height_raw_in = csr_wdata;
            default: ;
         endcase
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         filled_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_raw_ff  <= bb3_pkg::CFG_W_BITS'(1024);
         height_raw_ff <= bb3_pkg::CFG_H_BITS'(768);
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         filled_ff     <= '0;
         tr_ff         <= '0;
         tc_ff         <= '0;
         ch_ff         <= '0;
         rd_valid_ff   <= 1'b0;
      end else begin
         width_raw_ff  <= width_raw_in;
         height_raw_ff <= height_raw_in;
         in_col_ff     <= in_col_in;
         in_row_ff     <= in_row_in;
         out_col_ff    <= out_col_in;
         out_row_ff    <= out_row_in;
         filled_ff     <= filled_in;
         tr_ff         <= tr_in;
         tc_ff         <= tc_in;
         ch_ff         <= ch_in;
         rd_valid_ff   <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_col_ff  <= work_col_in;
      work_row_ff  <= work_row_in;
      work_last_ff <= work_last_in;
      cnt_ff       <= cnt_in;
      sum_ff       <= sum_in;
      if (cmd.mul) begin
         prod_ff <= PB'(div_x) * PB'(rc.mult);
      end
      if (cmd.shr) begin
         q_ff[ch_ff] <= CB'(prod_ff >> rc.shift);
      end
      if (cmd.load) begin
         rsp_data_ff <= {q_ff[2], q_ff[1], q_ff[0]};
         rsp_last_ff <= work_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && pix_ok) begin
         ring[wr_addr] <= req_tdata;
      end
      if (cmd.tap) begin
         rd_data_ff <= ring[rd_addr];
      end
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tlast = rsp_last_ff;

endmodule
`default_nettype wire

FILE: rtl/core/bb3_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bb3_checker (
   input wire clock,
   input wire reset,
   input wire req_tvalid,
   input wire req_tready,
   input wire rsp_tvalid,
   input wire rsp_tready
);

   // A stalled result word stays offered.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // No result is offered right after reset.
   `ASSERT_SAME(a_reset_quiet, clock, 1'b0, $past(reset), !rsp_tvalid)
   // A result needs its neighbor reads first, so an accepted word never raises the valid straight away.
   `ASSERT_NEXT(a_no_instant, clock, reset,
                req_tvalid && req_tready && !rsp_tvalid, !rsp_tvalid)

endmodule

bind box_blur_3x3_stream_unit bb3_checker u_bb3_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
`default_nettype wire

FILE: sim/bb3_checker.sv
`timescale 1ns / 1ps
module bb3_scoreboard (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_we,
   input  wire         csr_index,
   input  wire  [12:0] csr_wdata,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire  [23:0] req_tdata,
   input  wire         req_tuser,
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire  [23:0] rsp_tdata,
   input  wire         rsp_tlast,
   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      logic       last;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } blur_pixel_type;

   blur_pixel_type blurred_q[$];
   logic [23:0] frame_rows[4][1024];
   logic [10:0] width_reg;
   logic [12:0] height_reg;
   int in_col, in_row, out_col, out_row;

   function automatic int used_width();
      if (width_reg == 0) return 1;
      if (width_reg > 1024) return 1024;
      return int'(width_reg);
   endfunction

   function automatic int used_height();
      if (height_reg == 0) return 1;
      if (height_reg > 4096) return 4096;
      return int'(height_reg);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   // Averages the in-bounds neighborhood of the next output position.
   task automatic blur_next_pixel(input int w, input int h);
      int sums[3];
      int n, r, c;
      blur_pixel_type px;
      sums = '{0, 0, 0};
      n = 0;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            r = out_row + dr;
            c = out_col + dc;
            if (r >= 0 && r < h && c >= 0 && c < w) begin
               for (int k = 0; k < 3; k++) sums[k] += frame_rows[r & 3][c][8*k +: 8];
               n++;
            end
         end
      end
      px.red   = 8'((sums[0] + n / 2) / n);
      px.green = 8'((sums[1] + n / 2) / n);
      px.blue  = 8'((sums[2] + n / 2) / n);
      px.last  = (out_row + 1 >= h) && (out_col + 1 >= w);
      blurred_q.push_back(px);
      if (px.last) begin
         in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      end else begin
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
   endtask

   always @(posedge clock) begin
      int w, h;
      blur_pixel_type want;
      if (reset) begin
         width_reg <= 11'd1024;
         height_reg <= 13'd768;
         in_col = 0; in_row = 0; out_col = 0; out_row = 0;
         fail_count = 0;
         blurred_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (blurred_q.size() == 0) begin
               report_mismatch("result count", 1, 0);
            end else begin
               want = blurred_q.pop_front();
               if (rsp_tdata[7:0] != want.red) report_mismatch("red", rsp_tdata[7:0], want.red);
               if (rsp_tdata[15:8] != want.green)
                  report_mismatch("green", rsp_tdata[15:8], want.green);
               if (rsp_tdata[23:16] != want.blue)
                  report_mismatch("blue", rsp_tdata[23:16], want.blue);
               if (rsp_tlast != want.last) report_mismatch("last", rsp_tlast, want.last);
            end
         end
         if (req_tvalid && req_tready) begin
            w = used_width();
            h = used_height();
            if (req_tuser) begin
               if (in_row >= h) blur_next_pixel(w, h);
            end else if (in_row < h) begin
               frame_rows[in_row & 3][in_col] = req_tdata;
               in_col++;
               if (in_col >= w) begin
                  in_col = 0;
                  in_row++;
               end
               if (in_row * w + in_col >= w + 2) blur_next_pixel(w, h);
            end
         end
         if (csr_we) begin
            if (csr_index == bb3_pkg::REG_FRAME_WIDTH) width_reg <= csr_wdata[10:0];
            else height_reg <= csr_wdata;
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
         end
      end
      pending_count = blurred_q.size();
   end
endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic        csr_index = bb3_pkg::REG_FRAME_WIDTH;
   logic [12:0] csr_wdata = 0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = 0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   int          fail_count, pending_count;
   int          idle_cycles = 0;
   bit          quiet_phase = 0;
   bit          hold_rsp = 0;

   box_blur_3x3_stream_unit DUT (.*);

   bb3_scoreboard scoreboard_i (.*);

   initial forever #5 clock = ~clock;

   // Watchdog: cycles with no word moving on either channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request.
   initial begin
      int gap;
      @(posedge clock);
      while (1) begin
         if (hold_rsp) begin
            rsp_tready <= 0;
            repeat (400) @(posedge clock);
            hold_rsp = 0;
         end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
         end else begin
            rsp_tready <= 1;
            @(posedge clock);
         end
      end
   end

   // The valid stays high after acceptance; the next word may drop it for a random gap, and settle() drops it.
   task automatic send_word(input logic drain, input logic [23:0] rgb);
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= drain;
      req_tdata <= rgb;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(input bb3_pkg::reg_index_type idx, input logic [12:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // One full frame plus drains; a few strays exercise the ignore cases.
   task automatic run_frame(input int w, input int h, input bit extremes);
      logic [23:0] rgb;
      int n;
      n = w * h;
      if ($urandom_range(0, 3) == 0) send_word(1'b1, 24'($urandom));
      for (int i = 0; i < n; i++) begin
         if (extremes) rgb = (i % 2) ? 24'hFFFFFF : 24'h000000;
         else rgb = 24'($urandom);
         send_word(1'b0, rgb);
      end
      if ($urandom_range(0, 3) == 0) send_word(1'b0, 24'($urandom));
      for (int i = 0; i < w + 1 && i < n; i++) send_word(1'b1, 24'($urandom));
   endtask

   task automatic set_size(input int w, input int h);
      write_reg(bb3_pkg::REG_FRAME_WIDTH, 13'(w));
      write_reg(bb3_pkg::REG_FRAME_HEIGHT, 13'(h));
      csr_we <= 0;
   endtask

   // Part of a frame; the next register write starts over.
   task automatic run_partial(input int count);
      for (int i = 0; i < count; i++) send_word(1'b0, 24'($urandom));
   endtask

   initial begin
      int w, h, sent;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: tiny frames, one-pixel strips, zero and oversized settings.
      set_size(1, 1);   run_frame(1, 1, 1); settle();
      set_size(3, 1);   run_frame(3, 1, 1); settle();
      set_size(1, 3);   run_frame(1, 3, 0); settle();
      set_size(0, 0);   run_frame(1, 1, 0); settle();
      set_size(2, 2);   run_frame(2, 2, 1); settle();
      set_size(13'h7FF, 2);  run_partial(30); settle();
      set_size(2, 13'h1FFF); run_partial(30); settle();
      set_size(3, 3);
      hold_rsp = 1;
      run_frame(3, 3, 0);
      run_frame(3, 3, 0);
      settle();
      sent = 0;
      while (sent < 1000) begin
         w = $urandom_range(1, 8);
         h = $urandom_range(1, 8);
         if (sent > 820) quiet_phase = 1;
         set_size(w, h);
         repeat ($urandom_range(1, 2)) begin
            run_frame(w, h, 0);
            sent += w * h + w + 1;
         end
         settle();
      end
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/bb3_pkg.sv
rtl/core/bb3_ctrl.sv
rtl/core/bb3_datapath.sv
rtl/core/box_blur_3x3_stream_unit.sv
rtl/core/bb3_checker.sv
sim/bb3_checker.sv
sim/tb_top.sv
